### hdl/sls_pkg.sv
// Shared types and constants for the streaming source lexer.
// No dependencies; sls_scan, sls_outq and the top level import this package.
`default_nettype none

package sls_pkg;

  localparam int unsigned STREAM_BYTES = 65536;
  localparam logic [15:0] POS_LIMIT =
      (STREAM_BYTES - 1 < 65535) ? 16'(STREAM_BYTES - 1) : 16'hFFFF;

  localparam int unsigned RES_PER_BEAT = 3;
  localparam int unsigned QUEUE_DEPTH  = 4;

  localparam logic [4:0] KIND_IDENT    = 5'd0;
  localparam logic [4:0] KIND_NUMBER   = 5'd1;
  localparam logic [4:0] KIND_OPERATOR = 5'd2;
  localparam logic [4:0] KIND_SEMI     = 5'd3;
  localparam logic [4:0] KIND_COMMA    = 5'd4;
  localparam logic [4:0] KIND_LPAREN   = 5'd5;
  localparam logic [4:0] KIND_RPAREN   = 5'd6;
  localparam logic [4:0] KIND_LBRACE   = 5'd7;
  localparam logic [4:0] KIND_RBRACE   = 5'd8;
  localparam logic [4:0] KIND_END      = 5'd9;
  localparam logic [4:0] KIND_KW_INT   = 5'd10;
  localparam logic [4:0] KIND_KW_STR   = 5'd11;
  localparam logic [4:0] KIND_KW_CHAR  = 5'd12;
  localparam logic [4:0] KIND_KW_BOOL  = 5'd13;
  localparam logic [4:0] KIND_KW_HASH  = 5'd14;
  localparam logic [4:0] KIND_KW_ARR   = 5'd15;
  localparam logic [4:0] KIND_KW_VOID  = 5'd16;
  localparam logic [4:0] KIND_KW_FUNC  = 5'd17;
  localparam logic [4:0] KIND_KW_RET   = 5'd18;
  localparam logic [4:0] KIND_KW_IF    = 5'd19;
  localparam logic [4:0] KIND_KW_ELSE  = 5'd20;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        run_last;
  } sls_result_t;

  typedef struct packed {
    logic [1:0]                         count;
    sls_result_t [RES_PER_BEAT-1:0]     res;
  } sls_batch_t;

endpackage

`default_nettype wire

### hdl/sls_stream_if.sv
// Valid/ready channel interfaces for source bytes and tokens.
// Depends on nothing; used by the lexer top level and its queue.
`default_nettype none

interface sls_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface sls_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        run_last;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output run_last, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input run_last, output ready);
endinterface

`default_nettype wire

### hdl/sls_scan.sv
// Lexer state and per-byte token logic: one byte in, a batch of up to three tokens out.
// Depends on sls_pkg.
`default_nettype none

module sls_scan (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         byte_i,
  input  wire logic               last_i,
  output sls_pkg::sls_batch_t     batch_o
);
  import sls_pkg::*;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam int unsigned PREFIX_BYTES = 6;

  function automatic logic [4:0] kw_kind(input logic [5:0][7:0] p, input logic [2:0] len);
    logic [4:0] k;
    k = KIND_IDENT;
    if (len == 3'd3 && {p[0], p[1], p[2]} == "int")                     k = KIND_KW_INT;
    if (len == 3'd3 && {p[0], p[1], p[2]} == "str")                     k = KIND_KW_STR;
    if (len == 3'd4 && {p[0], p[1], p[2], p[3]} == "char")              k = KIND_KW_CHAR;
    if (len == 3'd4 && {p[0], p[1], p[2], p[3]} == "bool")              k = KIND_KW_BOOL;
    if (len == 3'd4 && {p[0], p[1], p[2], p[3]} == "hash")              k = KIND_KW_HASH;
    if (len == 3'd3 && {p[0], p[1], p[2]} == "arr")                     k = KIND_KW_ARR;
    if (len == 3'd4 && {p[0], p[1], p[2], p[3]} == "void")              k = KIND_KW_VOID;
    if (len == 3'd4 && {p[0], p[1], p[2], p[3]} == "func")              k = KIND_KW_FUNC;
    if (len == 3'd6 && {p[0], p[1], p[2], p[3], p[4], p[5]} == "return") k = KIND_KW_RET;
    if (len == 3'd2 && {p[0], p[1]} == "if")                            k = KIND_KW_IF;
    if (len == 3'd4 && {p[0], p[1], p[2], p[3]} == "else")              k = KIND_KW_ELSE;
    return k;
  endfunction

  logic                   quoted_q, quoted_d;
  logic                   comment_q, comment_d;
  logic [7:0]             prev_q, prev_d;
  logic [5:0][7:0]        prefix_q, prefix_d;
  logic [15:0]            len_q, len_d;
  logic                   digits_q, digits_d;
  logic [15:0]            start_q, start_d;
  logic [15:0]            pos_q, pos_d;

  logic                   is_digit, is_sep, is_op, quote_tog;
  logic                   single_v;
  logic [4:0]             single_k;
  logic                   delim, append;
  logic [5:0][7:0]        ap_prefix;
  logic [15:0]            ap_len, ap_start;
  logic                   ap_digits;
  logic [15:0]            pos_next;
  logic [5:0][7:0]        fl_prefix;
  logic [15:0]            fl_len, fl_start;
  logic                   fl_digits, fl_v;
  logic [4:0]             fl_kind;
  sls_result_t            fl_res, single_res, end_res;
  sls_batch_t             batch;
  logic [1:0]             n;

  assign is_digit  = (byte_i >= "0") && (byte_i <= "9");
  assign is_sep    = (byte_i == CH_SPACE) || (byte_i == CH_TAB) || (byte_i == CH_NL);
  assign quote_tog = ((byte_i == CH_DQUOTE) || (byte_i == CH_SQUOTE)) && (prev_q != CH_BSLASH);
  assign pos_next  = (pos_q < POS_LIMIT) ? pos_q + 16'd1 : pos_q;

  always_comb begin
    single_v = 1'b1;
    unique case (byte_i)
      ";":     single_k = KIND_SEMI;
      ",":     single_k = KIND_COMMA;
      "(":     single_k = KIND_LPAREN;
      ")":     single_k = KIND_RPAREN;
      "{":     single_k = KIND_LBRACE;
      "}":     single_k = KIND_RBRACE;
      default: begin
        single_k = KIND_IDENT;
        single_v = 1'b0;
      end
    endcase
  end

  always_comb begin
    ap_prefix = prefix_q;
    if (len_q < 16'(PREFIX_BYTES)) begin
      ap_prefix[len_q[2:0]] = byte_i;
    end
    ap_start  = (len_q == 16'd0) ? pos_q : start_q;
    ap_digits = digits_q & is_digit;
    ap_len    = (len_q != 16'hFFFF) ? len_q + 16'd1 : len_q;
  end

  always_comb begin
    quoted_d  = quoted_q;
    comment_d = comment_q;
    prev_d    = prev_q;
    prefix_d  = prefix_q;
    len_d     = len_q;
    digits_d  = digits_q;
    start_d   = start_q;
    pos_d     = pos_next;
    delim     = 1'b0;
    append    = 1'b0;
    if (comment_q) begin
      if (byte_i == CH_NL) begin
        comment_d = 1'b0;
      end
    end else begin
      quoted_d = quoted_q ^ quote_tog;
      if (!quoted_d && byte_i == CH_HASH) begin
        delim     = 1'b1;
        comment_d = 1'b1;
        prev_d    = CH_NL;
      end else begin
        prev_d = byte_i;
        if (is_sep || single_v) begin
          delim = 1'b1;
        end else begin
          append = 1'b1;
        end
      end
    end
    if (append) begin
      prefix_d = ap_prefix;
      len_d    = ap_len;
      digits_d = ap_digits;
      start_d  = ap_start;
    end
    if (delim || last_i) begin
      prefix_d = '0;
      len_d    = '0;
      digits_d = 1'b1;
      start_d  = '0;
    end
    if (last_i) begin
      quoted_d  = 1'b0;
      comment_d = 1'b0;
      prev_d    = '0;
      pos_d     = '0;
    end
  end

  // flush source: the token as it stands after this byte is appended
  always_comb begin
    fl_prefix = append ? ap_prefix : prefix_q;
    fl_len    = append ? ap_len    : len_q;
    fl_digits = append ? ap_digits : digits_q;
    fl_start  = append ? ap_start  : start_q;
    fl_v      = (delim || last_i) && (fl_len != 16'd0) &&
                !((fl_len == 16'd1) && (fl_prefix[0] == 8'd0));
    is_op     = (fl_prefix[0] == "+") || (fl_prefix[0] == "-") || (fl_prefix[0] == "*") ||
                (fl_prefix[0] == "/") || (fl_prefix[0] == "=");
    if (fl_len == 16'd1) begin
      if (is_op) begin
        fl_kind = KIND_OPERATOR;
      end else if (fl_digits) begin
        fl_kind = KIND_NUMBER;
      end else begin
        fl_kind = KIND_IDENT;
      end
    end else if (fl_digits) begin
      fl_kind = KIND_NUMBER;
    end else if (fl_len <= 16'(PREFIX_BYTES)) begin
      fl_kind = kw_kind(fl_prefix, fl_len[2:0]);
    end else begin
      fl_kind = KIND_IDENT;
    end
  end

  always_comb begin
    fl_res     = '{kind: fl_kind, start: fl_start, length: fl_len, run_last: 1'b0};
    single_res = '{kind: single_k, start: pos_q, length: 16'd1, run_last: 1'b0};
    end_res    = '{kind: KIND_END, start: pos_next, length: 16'd0, run_last: 1'b0};
    batch      = '0;
    n          = '0;
    if (fl_v) begin
      batch.res[n] = fl_res;
      n            = n + 2'd1;
    end
    if (delim && single_v) begin
      batch.res[n] = single_res;
      n            = n + 2'd1;
    end
    if (last_i) begin
      batch.res[n] = end_res;
      n            = n + 2'd1;
    end
    if (n != 2'd0) begin
      batch.res[n - 2'd1].run_last = 1'b1;
    end
    batch.count = accept_i ? n : 2'd0;
  end

  assign batch_o = batch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quoted_q  <= 1'b0;
      comment_q <= 1'b0;
      prev_q    <= '0;
      prefix_q  <= '0;
      len_q     <= '0;
      digits_q  <= 1'b1;
      start_q   <= '0;
      pos_q     <= '0;
    end else if (accept_i) begin
      quoted_q  <= quoted_d;
      comment_q <= comment_d;
      prev_q    <= prev_d;
      prefix_q  <= prefix_d;
      len_q     <= len_d;
      digits_q  <= digits_d;
      start_q   <= start_d;
      pos_q     <= pos_d;
    end
  end

endmodule

`default_nettype wire

### hdl/sls_outq.sv
// Token result queue: takes a batch of up to three tokens per beat, drains one per ready cycle.
// Depends on sls_pkg and sls_token_if.
`default_nettype none

module sls_outq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  sls_pkg::sls_batch_t  batch_i,
  output logic                 room_o,
  sls_token_if.source          tok_o
);
  import sls_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  sls_result_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 pop;
  sls_result_t          head;

  assign pop    = (cnt_q != '0) && tok_o.ready;
  assign room_o = cnt_q <= CW'(QUEUE_DEPTH - RES_PER_BEAT);
  assign cnt_d  = cnt_q + CW'(batch_i.count) - CW'(pop);
  assign head   = mem_q[rd_ptr_q];

  assign tok_o.valid        = cnt_q != '0;
  assign tok_o.token_kind   = head.kind;
  assign tok_o.token_start  = head.start;
  assign tok_o.token_length = head.length;
  assign tok_o.run_last     = head.run_last;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < RES_PER_BEAT; k++) begin
      if (2'(k) < batch_i.count) begin
        mem_q[wr_ptr_q + PW'(k)] <= batch_i.res[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PW'(batch_i.count);
      rd_ptr_q <= rd_ptr_q + PW'(pop);
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (batch_i.count != 2'd0) |-> room_o)
    else $error("batch written without room");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cnt_q == CW'(1) && batch_i.count == 2'd0) |=> (cnt_q == '0))
    else $error("queue did not drain");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("pointers differ on empty queue");

endmodule

`default_nettype wire

### hdl/streaming_source_lexer_core.sv
// Streaming source lexer top level: scanner plus token result queue.
// Depends on sls_pkg, sls_stream_if, sls_scan and sls_outq.
//
//   channel   dir  beat payload                                        handshake
//   byte_i    in   byte_in[7:0], last_byte                              valid/ready
//   token_o   out  token_kind[4:0], token_start[15:0], token_length[15:0], run_last
//                                                                       valid/ready
//
// One source byte per cycle while the queue has room; tokens leave a 4-entry queue
// at one per cycle while token_o.ready is high. With token_o.ready high, a byte
// yielding two or three tokens holds byte_i.ready low until one entry is left.
// byte_i.ready depends only on the queue fill, never on token_o.ready.
// Reset clears all lexer state; the beat after a last_byte starts at offset 0.
`default_nettype none

module streaming_source_lexer_core (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  sls_byte_if.sink     byte_i,
  sls_token_if.source  token_o
);
  import sls_pkg::*;

  logic        accept;
  logic        room;
  sls_batch_t  batch;

  assign byte_i.ready = room;
  assign accept       = byte_i.valid && room;

  sls_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (byte_i.byte_in),
    .last_i   (byte_i.last_byte),
    .batch_o  (batch)
  );

  sls_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .batch_i (batch),
    .room_o  (room),
    .tok_o   (token_o)
  );

endmodule

`default_nettype wire
